@@ rtl/contact_manifold_insert_macros.svh @@
// assertion macros used by the datapath file cmi_dp.sv
`ifndef CONTACT_MANIFOLD_INSERT_MACROS_SVH
`define CONTACT_MANIFOLD_INSERT_MACROS_SVH

`ifndef SYNTH
`define CMI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CMI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define CMI_ASSERT(lbl, prop, msg)
`define CMI_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ rtl/cmi_pkg.sv @@
package cmi_pkg;

  localparam int SLOTS   = 4;
  localparam int SLOT_W  = 2;
  localparam int COUNT_W = 3;

  localparam logic [1:0] ACT_MERGE   = 2'd0;
  localparam logic [1:0] ACT_APPEND  = 2'd1;
  localparam logic [1:0] ACT_REPLACE = 2'd2;

  localparam logic CFG_SAME_POINT = 1'b0;
  localparam logic CFG_ALIGNMENT  = 1'b1;

  localparam logic [31:0] SAME_POINT_RESET = 32'd42949673;
  localparam logic [28:0] ALIGNMENT_RESET  = 29'd265751101;

  typedef struct packed {
    logic signed [23:0] depth;
    logic signed [23:0] point_a_x;
    logic signed [23:0] point_a_y;
    logic signed [23:0] point_a_z;
    logic signed [23:0] point_b_x;
    logic signed [23:0] point_b_y;
    logic signed [23:0] point_b_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               is_mesh;
    logic [31:0]        facet_key;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [1:0]         action;
    logic [COUNT_W-1:0] count;
  } result_t;

  typedef struct packed {
    logic              load_item;
    logic              scan_clear;
    logic              scan_eval;
    logic              area_eval;
    logic              write_en;
    logic [1:0]        action;
    logic [SLOT_W-1:0] idx;
    logic [1:0]        k;
  } cmd_t;

  typedef struct packed {
    logic               hit;
    logic               cand;
    logic               found;
    logic               out_free;
    logic [COUNT_W-1:0] count;
  } status_t;

endpackage

@@ rtl/cmi_ctrl.sv @@
module cmi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              busy,
  input  cmi_pkg::status_t  status,
  output cmi_pkg::cmd_t     cmd
);

  // cycles from a new area index pair to a finished measure in the datapath
  localparam logic [2:0] AREA_LAT = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_SCAN_MUL, S_SCAN_SUM, S_SCAN_EV, S_AREA, S_WRITE
  } state_t;

  state_t                     state;
  logic [cmi_pkg::SLOT_W-1:0] idx;
  logic [1:0]                 k;
  logic [2:0]                 cnt;
  logic [1:0]                 action;
  logic                       last_slot;

  assign busy      = (state != S_IDLE);
  assign last_slot = ({1'b0, idx} == (status.count - 3'd1));

  always_comb begin
    cmd            = '0;
    cmd.load_item  = (state == S_IDLE) && item_valid;
    cmd.scan_clear = (state == S_START);
    cmd.scan_eval  = (state == S_SCAN_EV);
    cmd.area_eval  = (state == S_AREA) && (cnt == AREA_LAT);
    cmd.write_en   = (state == S_WRITE) && status.out_free;
    cmd.action     = action;
    cmd.idx        = idx;
    cmd.k          = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      idx    <= '0;
      k      <= '0;
      cnt    <= '0;
      action <= cmi_pkg::ACT_MERGE;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) state <= S_START;
        end
        S_START: begin
          idx <= '0;
          if (status.count == '0) begin
            action <= cmi_pkg::ACT_APPEND;
            state  <= S_WRITE;
          end else begin
            state <= S_SCAN_MUL;
          end
        end
        S_SCAN_MUL: state <= S_SCAN_SUM;
        S_SCAN_SUM: state <= S_SCAN_EV;
        S_SCAN_EV: begin
          if (status.hit) begin
            action <= cmi_pkg::ACT_MERGE;
            state  <= S_WRITE;
          end else if (last_slot) begin
            if (status.found || status.cand) begin
              action <= cmi_pkg::ACT_MERGE;
              state  <= S_WRITE;
            end else if (status.count < 3'(cmi_pkg::SLOTS)) begin
              action <= cmi_pkg::ACT_APPEND;
              state  <= S_WRITE;
            end else begin
              action <= cmi_pkg::ACT_REPLACE;
              idx    <= '0;
              k      <= '0;
              cnt    <= '0;
              state  <= S_AREA;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SCAN_MUL;
          end
        end
        S_AREA: begin
          if (cnt == AREA_LAT) begin
            cnt <= '0;
            if (k == 2'd2) begin
              k <= '0;
              if (idx == 2'(cmi_pkg::SLOTS - 1)) state <= S_WRITE;
              else idx <= idx + 1'b1;
            end else begin
              k <= k + 1'b1;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_WRITE: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/cmi_dp.sv @@
`include "contact_manifold_insert_macros.svh"

module cmi_dp (
  input  logic              clk,
  input  logic              rst,
  input  cmi_pkg::item_t    item,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  cmi_pkg::cmd_t     cmd,
  output cmi_pkg::status_t  status,
  output logic              result_valid,
  input  logic              result_stall,
  output cmi_pkg::result_t  result
);

  localparam int SN = cmi_pkg::SLOTS;

  function automatic logic signed [24:0] sub24(logic signed [23:0] x, logic signed [23:0] y);
    return {x[23], x} - {y[23], y};
  endfunction

  // square of a 25 bit signed difference, taken at full product width
  function automatic logic [49:0] sqr25(logic signed [24:0] x);
    logic signed [49:0] w;
    w = 50'(x);
    return 50'($unsigned(w * w));
  endfunction

  cmi_pkg::item_t item_q;
  logic [31:0]    same_limit;
  logic [28:0]    align_limit;

  logic signed [23:0] s_depth [SN];
  logic signed [23:0] s_pa    [SN][3];
  logic signed [23:0] s_pb    [SN][3];
  logic signed [15:0] s_n     [SN][3];
  logic               s_mesh  [SN];
  logic [31:0]        s_key   [SN];
  logic [cmi_pkg::COUNT_W-1:0] count;

  logic signed [23:0] ipa [3];
  logic signed [23:0] ipb [3];
  logic signed [15:0] inr [3];

  // match search state
  logic [31:0]               limit;
  logic                      found;
  logic [cmi_pkg::SLOT_W-1:0] match_id;
  logic signed [23:0]        deepest;
  logic                      deep_valid;
  logic [cmi_pkg::SLOT_W-1:0] deep_id;

  logic [49:0]        sq_a [3];
  logic [49:0]        sq_b [3];
  logic signed [31:0] np   [3];
  logic [51:0]        da, db;
  logic signed [33:0] dot;
  logic               near, hit, cand;
  logic [51:0]        lim_max;

  // area pipeline
  logic [cmi_pkg::SLOT_W-1:0] qi [3];
  logic [cmi_pkg::SLOT_W-1:0] ai, bi0, bi1;
  logic signed [24:0] av [3];
  logic signed [24:0] bv [3];
  logic signed [49:0] mp [6];
  logic [49:0]        mag [3];
  logic [49:0]        hh [3];
  logic [49:0]        hl [3];
  logic [49:0]        ll [3];
  logic [99:0]        sq [3];
  logic [101:0]       area_s;
  logic [101:0]       kbest, kb_next, slot_val, best_val;
  logic [cmi_pkg::SLOT_W-1:0] best_id;
  logic [cmi_pkg::SLOT_W-1:0] wr_id;
  logic [cmi_pkg::COUNT_W-1:0] count_next;

  always_comb begin
    ipa[0] = item_q.point_a_x; ipa[1] = item_q.point_a_y; ipa[2] = item_q.point_a_z;
    ipb[0] = item_q.point_b_x; ipb[1] = item_q.point_b_y; ipb[2] = item_q.point_b_z;
    inr[0] = item_q.normal_x;  inr[1] = item_q.normal_y;  inr[2] = item_q.normal_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      same_limit  <= cmi_pkg::SAME_POINT_RESET;
      align_limit <= cmi_pkg::ALIGNMENT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        cmi_pkg::CFG_SAME_POINT: same_limit  <= cfg_data;
        cmi_pkg::CFG_ALIGNMENT:  align_limit <= cfg_data[28:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_q <= item;
  end

  // scan pipeline: products, then sums
  always_ff @(posedge clk) begin
    for (int d = 0; d < 3; d++) begin
      sq_a[d] <= sqr25(sub24(s_pa[cmd.idx][d], ipa[d]));
      sq_b[d] <= sqr25(sub24(s_pb[cmd.idx][d], ipb[d]));
      np[d]   <= inr[d] * s_n[cmd.idx][d];
    end
    da  <= 52'(sq_a[0]) + 52'(sq_a[1]) + 52'(sq_a[2]);
    db  <= 52'(sq_b[0]) + 52'(sq_b[1]) + 52'(sq_b[2]);
    dot <= 34'(np[0]) + 34'(np[1]) + 34'(np[2]);
  end

  assign near    = (da < {20'd0, limit}) && (db < {20'd0, limit});
  assign hit     = near && s_mesh[cmd.idx] && (s_key[cmd.idx] == item_q.facet_key);
  assign cand    = near && (dot > $signed({5'd0, align_limit}));
  assign lim_max = (da > db) ? da : db;

  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      deep_valid <= 1'b0;
    end else if (cmd.scan_clear) begin
      found      <= 1'b0;
      deep_valid <= 1'b0;
    end else if (cmd.scan_eval) begin
      if (hit || cand) found <= 1'b1;
      if (s_depth[cmd.idx] < deepest) deep_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      limit    <= same_limit;
      deepest  <= item_q.depth;
      best_val <= '0;
      best_id  <= '0;
    end else begin
      if (cmd.scan_eval) begin
        if (hit) begin
          match_id <= cmd.idx;
        end else if (cand) begin
          match_id <= cmd.idx;
          limit    <= lim_max[31:0];
        end
        if (s_depth[cmd.idx] < deepest) begin
          deepest <= s_depth[cmd.idx];
          deep_id <= cmd.idx;
        end
      end
      if (cmd.area_eval) begin
        kbest <= kb_next;
        if (cmd.k == 2'd2 && slot_val > best_val) begin
          best_val <= slot_val;
          best_id  <= cmd.idx;
        end
      end
    end
  end

  // the three stored points other than the one being replaced, in slot order
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qi[j] = (2'(j) < cmd.idx) ? 2'(j) : 2'(j + 1);
    end
    case (cmd.k)
      2'd0:    begin ai = qi[0]; bi0 = qi[1]; bi1 = qi[2]; end
      2'd1:    begin ai = qi[1]; bi0 = qi[0]; bi1 = qi[2]; end
      default: begin ai = qi[2]; bi0 = qi[0]; bi1 = qi[1]; end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < 3; d++) begin
      av[d] <= sub24(ipa[d], s_pa[ai][d]);
      bv[d] <= sub24(s_pa[bi0][d], s_pa[bi1][d]);
    end
    mp[0] <= av[1] * bv[2];
    mp[1] <= av[2] * bv[1];
    mp[2] <= av[2] * bv[0];
    mp[3] <= av[0] * bv[2];
    mp[4] <= av[0] * bv[1];
    mp[5] <= av[1] * bv[0];
    for (int j = 0; j < 3; j++) begin
      automatic logic signed [50:0] c = 51'(mp[2*j]) - 51'(mp[2*j+1]);
      mag[j] <= c[50] ? 50'(-c) : c[49:0];
    end
    // square as split halves to keep each multiplier narrow
    for (int j = 0; j < 3; j++) begin
      hh[j] <= 50'(mag[j][49:25] * mag[j][49:25]);
      hl[j] <= 50'(mag[j][49:25] * mag[j][24:0]);
      ll[j] <= 50'(mag[j][24:0] * mag[j][24:0]);
    end
    for (int j = 0; j < 3; j++) begin
      sq[j] <= (100'(hh[j]) << 50) + (100'(hl[j]) << 26) + 100'(ll[j]);
    end
    area_s <= 102'(sq[0]) + 102'(sq[1]) + 102'(sq[2]);
  end

  assign kb_next  = (cmd.k == 2'd0 || area_s > kbest) ? area_s : kbest;
  assign slot_val = (deep_valid && deep_id == cmd.idx) ? '0 : kb_next;

  always_comb begin
    count_next = count;
    case (cmd.action)
      cmi_pkg::ACT_MERGE:  wr_id = match_id;
      cmi_pkg::ACT_APPEND: begin
        wr_id      = count[cmi_pkg::SLOT_W-1:0];
        count_next = count + 1'b1;
      end
      default:             wr_id = best_id;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.write_en) begin
      s_depth[wr_id] <= item_q.depth;
      for (int d = 0; d < 3; d++) begin
        s_pa[wr_id][d] <= ipa[d];
        s_pb[wr_id][d] <= ipb[d];
        s_n[wr_id][d]  <= inr[d];
      end
      s_mesh[wr_id] <= item_q.is_mesh;
      s_key[wr_id]  <= item_q.facet_key;
      result.slot   <= wr_id;
      result.action <= cmd.action;
      result.count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.write_en) count <= count_next;
      if (cmd.write_en) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_comb begin
    status.hit      = hit;
    status.cand     = cand;
    status.found    = found;
    status.out_free = !result_valid || !result_stall;
    status.count    = count;
  end

  `CMI_ASSERT(a_count_range, count <= 3'(cmi_pkg::SLOTS), "slot count beyond store size")
  `CMI_ASSERT_NEXT(a_append_grows, cmd.write_en && cmd.action == cmi_pkg::ACT_APPEND,
                   count == $past(count) + 3'd1, "append did not grow the count")
  `CMI_ASSERT(a_merge_found, (cmd.write_en && cmd.action == cmi_pkg::ACT_MERGE) |-> found,
              "merge without a matched slot")
  `CMI_ASSERT(a_match_valid, found |-> ({1'b0, match_id} < count),
              "matched slot is not a valid slot")

endmodule

@@ rtl/contact_manifold_insert.sv @@
// channel  direction  handshake                payload
// item     in         item_valid / item_stall  cmi_pkg::item_t
// result   out        result_valid / result_stall  cmi_pkg::result_t
// cfg      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// one item at a time: transfer, a setup state, a multiply, sum and evaluate step per
// valid slot searched, then a write state; with a full store and no match the area
// pass adds 12 measures through the multiply pipeline
// reset empties the store; slot contents are not cleared
// a result waiting under result_stall holds the write cycle; a new item may be
// taken while the previous result still waits
module contact_manifold_insert (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  cmi_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output cmi_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);

  cmi_pkg::cmd_t    cmd;
  cmi_pkg::status_t status;
  logic             busy;

  assign item_stall = busy;
  assign cfg_ready  = 1'b1;

  cmi_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .busy       (busy),
    .status     (status),
    .cmd        (cmd)
  );

  cmi_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ verif/contact_manifold_checker.sv @@
`timescale 1ns / 100ps

module contact_manifold_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  cmi_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  cmi_pkg::result_t result,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  output int               errors,
  output int               pending
);
  import cmi_pkg::*;

  logic [31:0] same_limit;
  logic [28:0] align_limit;
  logic signed [23:0] st_depth [SLOTS];
  logic signed [23:0] st_pa [SLOTS][3];
  logic signed [23:0] st_pb [SLOTS][3];
  logic signed [15:0] st_nr [SLOTS][3];
  logic st_mesh [SLOTS];
  logic [31:0] st_key [SLOTS];
  int unsigned occupied;
  result_t placements [$];

  assign pending = placements.size();

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] dist2(input logic signed [23:0] s [3],
                                        input logic signed [23:0] p [3]);
    logic signed [63:0] e;
    logic [63:0] acc;
    acc = 0;
    for (int d = 0; d < 3; d++) begin
      e = 64'(s[d]) - 64'(p[d]);
      acc += 64'(e * e);
    end
    return acc;
  endfunction

  // largest squared cross product over the three diagonal pairings
  function automatic logic [127:0] quad_measure(input logic signed [63:0] q [4][3]);
    logic signed [63:0] a [3][3];
    logic signed [63:0] b [3][3];
    logic signed [127:0] c [3];
    logic [127:0] s, top;
    top = 0;
    for (int d = 0; d < 3; d++) begin
      a[0][d] = q[0][d] - q[1][d];
      a[1][d] = q[0][d] - q[2][d];
      a[2][d] = q[0][d] - q[3][d];
      b[0][d] = q[2][d] - q[3][d];
      b[1][d] = q[1][d] - q[3][d];
      b[2][d] = q[1][d] - q[2][d];
    end
    for (int k = 0; k < 3; k++) begin
      c[0] = 128'(a[k][1] * b[k][2] - a[k][2] * b[k][1]);
      c[1] = 128'(a[k][2] * b[k][0] - a[k][0] * b[k][2]);
      c[2] = 128'(a[k][0] * b[k][1] - a[k][1] * b[k][0]);
      s = 128'(c[0] * c[0]) + 128'(c[1] * c[1]) + 128'(c[2] * c[2]);
      if (k == 0 || s > top) top = s;
    end
    return top;
  endfunction

  task automatic place_contact(input item_t it);
    logic signed [23:0] pa [3];
    logic signed [23:0] pb [3];
    logic signed [15:0] nr [3];
    logic signed [63:0] q [4][3];
    logic [127:0] meas [SLOTS];
    logic [63:0] lim, da, db;
    logic signed [63:0] dot, deepest;
    int id, deep, pick, n;
    logic [1:0] act;
    pa = '{it.point_a_x, it.point_a_y, it.point_a_z};
    pb = '{it.point_b_x, it.point_b_y, it.point_b_z};
    nr = '{it.normal_x, it.normal_y, it.normal_z};
    lim = 64'(same_limit);
    id = -1;
    act = ACT_MERGE;
    for (int i = 0; i < int'(occupied); i++) begin
      da = dist2(st_pa[i], pa);
      db = dist2(st_pb[i], pb);
      if (da < lim && db < lim && st_mesh[i] && st_key[i] == it.facet_key) begin
        id = i;
        break;
      end
      dot = 0;
      for (int d = 0; d < 3; d++) dot += 64'(nr[d]) * 64'(st_nr[i][d]);
      if (da < lim && db < lim && dot > $signed(64'(align_limit))) begin
        lim = (da > db) ? da : db;
        id = i;
      end
    end
    if (id < 0 && occupied < SLOTS) begin
      id = occupied;
      occupied++;
      act = ACT_APPEND;
    end else if (id < 0) begin
      deep = -1;
      deepest = 64'(it.depth);
      for (int i = 0; i < SLOTS; i++)
        if (64'(st_depth[i]) < deepest) begin
          deepest = 64'(st_depth[i]);
          deep = i;
        end
      for (int i = 0; i < SLOTS; i++) begin
        meas[i] = 0;
        if (i != deep) begin
          for (int d = 0; d < 3; d++) q[0][d] = 64'(pa[d]);
          n = 1;
          for (int j = 0; j < SLOTS; j++)
            if (j != i) begin
              for (int d = 0; d < 3; d++) q[n][d] = 64'(st_pa[j][d]);
              n++;
            end
          meas[i] = quad_measure(q);
        end
      end
      pick = 0;
      for (int i = 1; i < SLOTS; i++) if (meas[i] > meas[pick]) pick = i;
      id = pick;
      act = ACT_REPLACE;
    end
    st_depth[id] = it.depth;
    st_pa[id] = pa;
    st_pb[id] = pb;
    st_nr[id] = nr;
    st_mesh[id] = it.is_mesh;
    st_key[id] = it.facet_key;
    placements.push_back('{slot: id[1:0], action: act, count: occupied[2:0]});
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      same_limit <= SAME_POINT_RESET;
      align_limit <= ALIGNMENT_RESET;
      occupied = 0;
      placements.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SAME_POINT) same_limit <= cfg_data;
        else align_limit <= cfg_data[28:0];
      end
      if (item_valid && !item_stall) place_contact(item);
      if (result_valid && !result_stall) begin
        if (placements.size() == 0) begin
          $display("unexpected result transfer");
          errors++;
        end else begin
          want = placements.pop_front();
          if (result.slot !== want.slot) report("slot", 8'(result.slot), 8'(want.slot));
          if (result.action !== want.action)
            report("action", 8'(result.action), 8'(want.action));
          if (result.count !== want.count)
            report("count", 8'(result.count), 8'(want.count));
        end
      end
    end
  end
endmodule

@@ verif/tb_contact_manifold_insert.sv @@
`timescale 1ns / 100ps

module tb_contact_manifold_insert;
  import cmi_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 0;
  result_t result;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = CFG_SAME_POINT;
  logic [31:0] cfg_data = '0;
  int errors, pending;
  int cycles = 0;
  bit stall_free = 0;
  item_t base;

  always #4 clk = ~clk;

  contact_manifold_insert dut (.*);
  contact_manifold_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("tb_contact_manifold_insert: done, errors");
      $finish;
    end
  end

  // receiver side: random stall stretches, sometimes none at all
  always begin
    int w;
    @(negedge clk);
    if (stall_free || $urandom_range(3) == 0) begin
      result_stall <= 0;
    end else begin
      w = $urandom_range(6);
      if (w != 0) begin
        result_stall <= 1;
        repeat (w) @(negedge clk);
      end
      result_stall <= 0;
    end
  end

  // valid stays high after the transfer; the caller drops it
  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send(input item_t it, input bit gaps);
    int w;
    w = gaps ? $urandom_range(6) : 0;
    if (w != 0) begin
      item_valid <= 0;
      repeat (w) @(negedge clk);
    end
    item <= it;
    item_valid <= 1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rnd_normal();
    case ($urandom_range(3))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic item_t rnd_item();
    item_t it;
    it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom});
    it.normal_x = rnd_normal();
    it.normal_y = rnd_normal();
    it.normal_z = rnd_normal();
    return it;
  endfunction

  // contact near base: tiny point offsets, usually the same normal, same facet half the time
  function automatic item_t near_item(input item_t b, input int spread);
    item_t it;
    it = b;
    it.depth = 24'($urandom);
    it.point_a_x = b.point_a_x + 24'($signed($urandom_range(2 * spread)) - spread);
    it.point_a_y = b.point_a_y + 24'($signed($urandom_range(2 * spread)) - spread);
    it.point_b_z = b.point_b_z + 24'($signed($urandom_range(2 * spread)) - spread);
    if ($urandom_range(1)) it.facet_key = $urandom;
    if ($urandom_range(2) == 0) it.normal_x = rnd_normal();
    return it;
  endfunction

  function automatic item_t small_item();
    item_t it;
    it = rnd_item();
    it.point_a_x = 24'($signed($urandom_range(2000)) - 1000);
    it.point_a_y = 24'($signed($urandom_range(2000)) - 1000);
    it.point_a_z = 24'($signed($urandom_range(2000)) - 1000);
    it.point_b_x = 24'($signed($urandom_range(2000)) - 1000);
    it.point_b_y = 24'($signed($urandom_range(2000)) - 1000);
    it.point_b_z = 24'($signed($urandom_range(2000)) - 1000);
    it.normal_x = 16'sd16384;
    it.normal_y = 0;
    it.normal_z = 0;
    return it;
  endfunction

  initial begin
    item_t it;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: appends, exact mesh hit, normal merge, full store, extremes
    stall_free = 1;
    base = '0;
    base.normal_z = 16'sd16384;
    base.is_mesh = 1;
    base.facet_key = 32'hdead_0001;
    send(base, 0);
    send(base, 0);
    it = base;
    it.is_mesh = 0;
    it.facet_key = 32'h0;
    send(it, 0);
    it = base;
    it.point_a_x = 24'sh7fffff;
    it.point_b_y = -24'sh800000;
    it.depth = -24'sh800000;
    send(it, 0);
    it.point_a_x = -24'sh800000;
    it.point_a_y = 24'sh7fffff;
    it.depth = 24'sh7fffff;
    send(it, 0);
    it.point_a_z = 24'sh7fffff;
    send(it, 0);
    for (int i = 0; i < 6; i++) send(rnd_item(), 0);
    it = '1;
    send(it, 0);
    it = '0;
    send(it, 0);
    for (int i = 0; i < 5; i++) send(small_item(), 0);
    drain();
    stall_free = 0;

    // phases across register settings, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin write_reg(CFG_SAME_POINT, 32'hffff_ffff); write_reg(CFG_ALIGNMENT, 29'd0); end
        1: begin write_reg(CFG_SAME_POINT, 32'd0); write_reg(CFG_ALIGNMENT, 29'd268435456); end
        2: begin write_reg(CFG_SAME_POINT, SAME_POINT_RESET);
                 write_reg(CFG_ALIGNMENT, ALIGNMENT_RESET); end
        3: begin write_reg(CFG_SAME_POINT, 32'd4000000); write_reg(CFG_ALIGNMENT, 29'd200000000); end
        4: begin write_reg(CFG_SAME_POINT, $urandom); write_reg(CFG_ALIGNMENT, 29'($urandom)); end
        5: begin write_reg(CFG_SAME_POINT, 32'd1); write_reg(CFG_ALIGNMENT, 29'h1fff_ffff); end
        default: begin write_reg(CFG_SAME_POINT, 32'hffff_ffff);
                       write_reg(CFG_ALIGNMENT, ALIGNMENT_RESET); end
      endcase
      cfg_valid <= 0;
      stall_free = (ph == 3);
      for (int i = 0; i < 250; i++) begin
        case ($urandom_range(9))
          0, 1: base = small_item();
          2: base = rnd_item();
          default: ;
        endcase
        if ($urandom_range(9) < 7) it = near_item(base, 300 * (1 + $urandom_range(3)));
        else it = ($urandom_range(1)) ? rnd_item() : small_item();
        send(it, ph != 3);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb_contact_manifold_insert: done, clean");
    end else begin
      $display("tb_contact_manifold_insert: done, errors");
    end
    $finish;
  end
endmodule
